### hdl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge out of reset.
`define CHK_IMPLY(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |-> (cons)) \
		else $error("fcep port check failed");

// Next-cycle implication, checked at every rising edge out of reset.
`define CHK_NEXT(lbl, ck, rn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (ante) |=> (cons)) \
		else $error("fcep port check failed");

`endif

### hdl/fcep_pkg.sv
`timescale 1ns / 1ps

package fcep_pkg;

	// Pattern sizes and field widths.
	localparam int PAT_BITS   = 64;
	localparam int OSD_BITS   = 16;
	localparam int PAT_IDX_W  = $clog2(PAT_BITS);
	localparam int LEN_W      = PAT_IDX_W + 1;
	localparam int OSD_LEN_W  = $clog2(OSD_BITS) + 1;
	localparam int RATIO_W    = 7;
	localparam int MBIT_W     = $clog2(RATIO_W);
	localparam int CTRL_W     = 12;
	localparam int PER_W      = 4;
	localparam int NARROW_BIT = 11;
	localparam int STEP_W     = 3;

	// One input item: the clock ratio.
	typedef struct packed {
		logic [RATIO_W-1:0] ratio_mult;
		logic [RATIO_W-1:0] ratio_div;
	} ratio_t;

	// One result item: the generator programming words.
	typedef struct packed {
		logic [PAT_BITS-1:0] dclk_pattern;
		logic [CTRL_W-1:0]   dclk_control;
		logic [PER_W-1:0]    osd_clock_period;
		logic [OSD_BITS-1:0] osd_pattern;
	} prog_t;

	// Datapath operations selected by the microcode.
	typedef enum logic [2:0] {
		OP_IDLE,
		OP_MOD,
		OP_SEED,
		OP_CELL,
		OP_EMIT,
		OP_NOP
	} op_t;

	// Jump conditions; when the condition holds the sequencer jumps to the target.
	typedef enum logic [2:0] {
		C_NEVER,
		C_ALWAYS,
		C_NO_ITEM,
		C_MORE,
		C_OUT_BUSY
	} cond_t;

	// Program addresses.
	localparam logic [STEP_W-1:0] ST_IDLE = STEP_W'(0);
	localparam logic [STEP_W-1:0] ST_MOD  = STEP_W'(1);
	localparam logic [STEP_W-1:0] ST_SEED = STEP_W'(2);
	localparam logic [STEP_W-1:0] ST_CELL = STEP_W'(3);
	localparam logic [STEP_W-1:0] ST_EMIT = STEP_W'(4);
	localparam logic [STEP_W-1:0] ST_RET  = STEP_W'(5);

	// One control word of the program.
	typedef struct packed {
		op_t                  op;
		cond_t                cond;
		logic [STEP_W-1:0]    target;
		logic [PAT_IDX_W-1:0] last;
	} uword_t;

	// Control passed from the sequencer to the datapath.
	typedef struct packed {
		op_t                  op;
		logic [PAT_IDX_W-1:0] cnt;
	} seq_ctl_t;

	// Microcode store: the whole program for one item.
	function automatic uword_t ucode(input logic [STEP_W-1:0] step);
		uword_t w;
		w.op     = OP_NOP;
		w.cond   = C_ALWAYS;
		w.target = ST_IDLE;
		w.last   = '0;
		unique case (step)
			ST_IDLE: begin
				w.op     = OP_IDLE;
				w.cond   = C_NO_ITEM;
				w.target = ST_IDLE;
			end
			ST_MOD: begin
				w.op     = OP_MOD;
				w.cond   = C_MORE;
				w.target = ST_MOD;
				w.last   = PAT_IDX_W'(RATIO_W - 1);
			end
			ST_SEED: begin
				w.op   = OP_SEED;
				w.cond = C_NEVER;
			end
			ST_CELL: begin
				w.op     = OP_CELL;
				w.cond   = C_MORE;
				w.target = ST_CELL;
				w.last   = PAT_IDX_W'(PAT_BITS - 1);
			end
			ST_EMIT: begin
				w.op     = OP_EMIT;
				w.cond   = C_OUT_BUSY;
				w.target = ST_EMIT;
			end
			ST_RET: begin
				w.op     = OP_NOP;
				w.cond   = C_ALWAYS;
				w.target = ST_IDLE;
			end
			default: begin
				w.op = OP_NOP;
			end
		endcase
		return w;
	endfunction

endpackage

### hdl/fcep_seq.sv
`timescale 1ns / 1ps

module fcep_seq import fcep_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     item_valid,
	input  logic     out_busy,
	output seq_ctl_t ctl
);

	logic [STEP_W-1:0]    step_q, step_d;
	logic [PAT_IDX_W-1:0] cnt_q, cnt_d;
	uword_t               uw;
	logic                 take;

	// Fetch the control word and evaluate its jump condition.
	always_comb begin
		uw = ucode(step_q);
		unique case (uw.cond)
			C_NEVER:    take = 1'b0;
			C_ALWAYS:   take = 1'b1;
			C_NO_ITEM:  take = !item_valid;
			C_MORE:     take = (cnt_q != uw.last);
			C_OUT_BUSY: take = out_busy;
			default:    take = 1'b1;
		endcase
		step_d = take ? uw.target : step_q + STEP_W'(1);
		// The loop counter runs only inside a counted loop and restarts on exit.
		if (uw.cond == C_MORE && take) begin
			cnt_d = cnt_q + PAT_IDX_W'(1);
		end else begin
			cnt_d = '0;
		end
	end

	// Step counter and loop counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= ST_IDLE;
			cnt_q  <= '0;
		end else begin
			step_q <= step_d;
			cnt_q  <= cnt_d;
		end
	end

	assign ctl.op  = uw.op;
	assign ctl.cnt = cnt_q;

endmodule

### hdl/fractional_clock_enable_pattern.sv
// Each item runs through the microcode steps in order: the 7-step remainder loop,
// the seed, the 64-step cell walk and the emit step, which waits while an untaken
// result blocks the output; a new item is taken only back in the idle step.
// A finished result waits in the output register while the next item is taken.
// Reset: asynchronous, active low; the sequencer returns to idle, no result pending.
`timescale 1ns / 1ps

module fractional_clock_enable_pattern import fcep_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   ratio_valid,
	output logic   ratio_stall,
	input  ratio_t ratio,
	output logic   prog_valid,
	input  logic   prog_stall,
	output prog_t  prog
);

	seq_ctl_t ctl;
	logic     out_busy;

	// Working registers of the datapath.
	logic [RATIO_W-1:0]   m_q, d_q, r_q, e_q, eo_q, u_q, t_q;
	logic                 narrow_q;
	logic [PAT_BITS-1:0]  pat_q;
	logic [OSD_BITS-1:0]  osd_q;
	logic [LEN_W-1:0]     len_q;
	logic [OSD_LEN_W-1:0] per_q;
	prog_t                prog_q;
	logic                 prog_valid_q;

	// Combinational values of the datapath.
	logic [MBIT_W-1:0]    mbit;
	logic [RATIO_W:0]     rsh, u_sum;
	logic [RATIO_W-1:0]   r_nx, pulse, sub0, need, e_nx, eo_nx, u_nx, t_inc;
	logic                 wide_mode, wide_hit, e_hit, eo_hit, pat_bit, osd_bit, wrap;
	logic [LEN_W-1:0]     c1;
	logic [LEN_W-1:0]     len_m1;
	logic [OSD_LEN_W-1:0] per_m1;
	prog_t                result;

	fcep_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (ratio_valid),
		.out_busy   (out_busy),
		.ctl        (ctl)
	);

	assign ratio_stall = (ctl.op != OP_IDLE);
	assign out_busy    = prog_valid_q && prog_stall;

	// Remainder step, pulse geometry and per-cell decisions.
	always_comb begin
		mbit  = MBIT_W'(RATIO_W - 1) - ctl.cnt[MBIT_W-1:0];
		rsh   = {r_q, m_q[mbit]};
		r_nx  = (rsh >= {1'b0, d_q}) ? RATIO_W'(rsh - {1'b0, d_q}) : rsh[RATIO_W-1:0];

		pulse = d_q >> 1;
		sub0  = pulse - (pulse >> 1);
		need  = (m_q >> 1) + RATIO_W'(1);
		wide_mode = ({m_q, 1'b0} <= {1'b0, d_q});

		// Wide cells: pulse coverage of the cell against the threshold.
		u_sum    = {1'b0, u_q} + {1'b0, m_q};
		wide_hit = (({1'b0, u_q} + {1'b0, need}) <= {1'b0, pulse}) ||
			(u_sum >= ({1'b0, d_q} + {1'b0, need}));
		u_nx     = (u_sum >= {1'b0, d_q}) ? RATIO_W'(u_sum - {1'b0, d_q})
			: u_sum[RATIO_W-1:0];

		// Point cells: a pixel midpoint falls in the cell when the phase is below m.
		e_hit  = (e_q < m_q);
		eo_hit = (eo_q < m_q);
		e_nx   = (e_q >= r_q) ? e_q - r_q : e_q - r_q + d_q;
		eo_nx  = (eo_q >= r_q) ? eo_q - r_q : eo_q - r_q + d_q;

		pat_bit = narrow_q ? e_hit : wide_hit;
		osd_bit = narrow_q ? e_hit : eo_hit;

		// Track the largest multiple of div seen so far.
		t_inc = t_q + RATIO_W'(1);
		wrap  = (t_inc == d_q);
		c1    = {1'b0, ctl.cnt} + LEN_W'(1);

		// Assemble the result item.
		len_m1 = len_q - LEN_W'(1);
		per_m1 = per_q - OSD_LEN_W'(1);
		result.dclk_pattern     = pat_q;
		result.dclk_control     = '0;
		result.dclk_control[PAT_IDX_W-1:0] = len_m1[PAT_IDX_W-1:0];
		result.dclk_control[NARROW_BIT]    = narrow_q;
		result.osd_clock_period = per_m1[PER_W-1:0];
		result.osd_pattern      = osd_q;
	end

	// Datapath registers, driven by the operation of the current step.
	always_ff @(posedge clk) begin
		unique case (ctl.op)
			OP_IDLE: begin
				m_q <= (ratio.ratio_mult == '0) ? RATIO_W'(1) : ratio.ratio_mult;
				d_q <= (ratio.ratio_div == '0) ? RATIO_W'(1) : ratio.ratio_div;
				r_q <= '0;
			end
			OP_MOD: begin
				r_q <= r_nx;
			end
			OP_SEED: begin
				narrow_q <= !wide_mode;
				e_q      <= wide_mode ? '0 : pulse;
				eo_q     <= '0;
				u_q      <= d_q - sub0;
				t_q      <= '0;
				len_q    <= LEN_W'(PAT_BITS);
				per_q    <= OSD_LEN_W'(OSD_BITS);
			end
			OP_CELL: begin
				pat_q <= {pat_bit, pat_q[PAT_BITS-1:1]};
				if (ctl.cnt < PAT_IDX_W'(OSD_BITS)) begin
					osd_q <= {osd_bit, osd_q[OSD_BITS-1:1]};
				end
				e_q  <= e_nx;
				eo_q <= eo_nx;
				u_q  <= u_nx;
				if (wrap) begin
					t_q   <= '0;
					len_q <= c1;
					if (c1 <= LEN_W'(OSD_BITS)) begin
						per_q <= OSD_LEN_W'(c1);
					end
				end else begin
					t_q <= t_inc;
				end
			end
			OP_EMIT: begin
				if (!out_busy) begin
					prog_q <= result;
				end
			end
			OP_NOP: begin
				r_q <= r_q;
			end
			default: begin
				r_q <= r_q;
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prog_valid_q <= 1'b0;
		end else if (ctl.op == OP_EMIT && !out_busy) begin
			prog_valid_q <= 1'b1;
		end else if (!prog_stall) begin
			prog_valid_q <= 1'b0;
		end
	end

	assign prog_valid = prog_valid_q;
	assign prog       = prog_q;

endmodule

### hdl/fcep_chk.sv
`timescale 1ns / 1ps
`include "assert_macros.svh"

module fcep_chk import fcep_pkg::*; (
	input logic  clk,
	input logic  arst_n,
	input logic  ratio_valid,
	input logic  ratio_stall,
	input logic  prog_valid,
	input logic  prog_stall,
	input prog_t prog
);

	// A result item held under stall keeps its value.
	`CHK_NEXT(a_hold, clk, arst_n, prog_valid && prog_stall, prog_valid && $stable(prog))

	// One item at a time: the cycle after an item is taken, input stalls.
	`CHK_NEXT(a_one_item, clk, arst_n, ratio_valid && !ratio_stall, ratio_stall)

	// Narrow cells reuse the low pattern bits as the display clock pattern.
	`CHK_IMPLY(a_narrow_osd, clk, arst_n, prog_valid && prog.dclk_control[NARROW_BIT], prog.osd_pattern == prog.dclk_pattern[OSD_BITS-1:0])

	// The length field never exceeds the pattern size.
	`CHK_IMPLY(a_ctrl_len, clk, arst_n, prog_valid, prog.dclk_control[NARROW_BIT-1:PAT_IDX_W] == '0)

endmodule

bind fractional_clock_enable_pattern fcep_chk u_fcep_chk (
	.clk         (clk),
	.arst_n      (arst_n),
	.ratio_valid (ratio_valid),
	.ratio_stall (ratio_stall),
	.prog_valid  (prog_valid),
	.prog_stall  (prog_stall),
	.prog        (prog)
);

### tb/tb.sv
`timescale 1ns / 1ps

import fcep_pkg::*;

// Keeps the programming words still owed by the block and checks each result against them.
class prog_checker;
	prog_t pending_progs[$];
	int    mismatches;

	// Marks the cell holding each pixel point, starting at sub-unit offset first_sub.
	static function automatic logic [PAT_BITS-1:0] mark_points(int unsigned m, int unsigned d,
			int unsigned first_sub, int unsigned cells);
		logic [PAT_BITS-1:0] bits;
		int unsigned         pos;
		int unsigned         sub;
		bits = '0;
		pos  = 0;
		sub  = first_sub;
		forever begin
			while (sub >= m) begin
				sub -= m;
				pos++;
			end
			if (pos >= cells)
				break;
			bits[pos] = 1'b1;
			sub += d;
		end
		return bits;
	endfunction

	// Wide cells: a cell is set when the pixel pulse covers more than half of it.
	static function automatic logic [PAT_BITS-1:0] mark_pulses(int unsigned m, int unsigned d);
		logic [PAT_BITS-1:0] bits;
		int unsigned         pulse;
		int unsigned         need;
		int unsigned         pos;
		int unsigned         sub;
		int unsigned         covered;
		int unsigned         rest;
		int unsigned         nxt;
		bits  = '0;
		pulse = d >> 1;
		need  = (m >> 1) + 1;
		pos   = 0;
		sub   = pulse - (pulse >> 1);
		forever begin
			while (sub >= m) begin
				sub -= m;
				pos++;
			end
			if (pos >= PAT_BITS)
				break;
			covered = m - sub;
			if (covered >= need)
				bits[pos] = 1'b1;
			nxt  = pos + 1;
			rest = pulse - covered;
			while (rest >= m) begin
				if (nxt >= PAT_BITS)
					break;
				bits[nxt] = 1'b1;
				rest -= m;
				nxt++;
			end
			// The pulse ran past the last cell: nothing further is marked.
			if (nxt >= PAT_BITS)
				break;
			if (rest >= need)
				bits[nxt] = 1'b1;
			sub += d;
		end
		return bits;
	endfunction

	// Computes the generator words for one clock ratio.
	static function automatic prog_t ratio_to_prog(ratio_t r);
		prog_t               p;
		int unsigned         m;
		int unsigned         d;
		int unsigned         len;
		logic [PAT_BITS-1:0] pat;
		logic [PAT_BITS-1:0] osd;
		logic [CTRL_W-1:0]   ctrl;
		m = r.ratio_mult;
		d = r.ratio_div;
		// A zero term of the ratio counts as one.
		if (m == 0)
			m = 1;
		if (d == 0)
			d = 1;
		len  = (d > PAT_BITS) ? PAT_BITS : (PAT_BITS / d) * d;
		ctrl = CTRL_W'(len - 1);
		if (2 * m <= d) begin
			pat = mark_pulses(m, d);
			osd = mark_points(m, d, 0, OSD_BITS);
		end else begin
			pat = mark_points(m, d, d >> 1, PAT_BITS);
			ctrl[NARROW_BIT] = 1'b1;
			osd = pat;
		end
		p.dclk_pattern     = pat;
		p.dclk_control     = ctrl;
		p.osd_clock_period = PER_W'((d <= OSD_BITS) ? (OSD_BITS / d) * d - 1 : OSD_BITS - 1);
		p.osd_pattern      = osd[OSD_BITS-1:0];
		return p;
	endfunction

	function void note_ratio(ratio_t r);
		pending_progs.push_back(ratio_to_prog(r));
	endfunction

	function void report(string what, logic [PAT_BITS-1:0] want, logic [PAT_BITS-1:0] got);
		mismatches++;
		if (mismatches <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, got);
	endfunction

	function void check_prog(prog_t got);
		prog_t want;
		if (pending_progs.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("%0t: result item with nothing outstanding: %h", $realtime, got);
			return;
		end
		want = pending_progs.pop_front();
		if (got.dclk_pattern !== want.dclk_pattern)
			report("dclk_pattern", want.dclk_pattern, got.dclk_pattern);
		if (got.dclk_control !== want.dclk_control)
			report("dclk_control", PAT_BITS'(want.dclk_control), PAT_BITS'(got.dclk_control));
		if (got.osd_clock_period !== want.osd_clock_period)
			report("osd_clock_period", PAT_BITS'(want.osd_clock_period),
				PAT_BITS'(got.osd_clock_period));
		if (got.osd_pattern !== want.osd_pattern)
			report("osd_pattern", PAT_BITS'(want.osd_pattern), PAT_BITS'(got.osd_pattern));
	endfunction

	function int outstanding();
		return pending_progs.size();
	endfunction
endclass

module tb;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 400;
	localparam int SETTLE      = 100;
	localparam int N_DIRECTED  = 24;
	localparam int N_RANDOM    = 400;

	// Directed ratios: extremes, zero terms, mode boundaries and oversized divisors.
	localparam logic [RATIO_W-1:0] DIR_MULT [N_DIRECTED] = '{
		1, 64, 1, 64, 0, 0, 3, 127, 1, 1, 2, 32,
		33, 1, 1, 5, 63, 7, 10, 100, 2, 16, 1, 3};
	localparam logic [RATIO_W-1:0] DIR_DIV [N_DIRECTED] = '{
		1, 64, 64, 1, 0, 5, 0, 127, 127, 2, 3, 64,
		64, 16, 17, 65, 127, 13, 63, 3, 5, 16, 3, 48};

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   ratio_valid = 1'b0;
	logic   ratio_stall;
	ratio_t ratio = '0;
	logic   prog_valid;
	logic   prog_stall = 1'b0;
	prog_t  prog;

	prog_checker board = new();
	int          cycles = 0;
	int          send_max_gap = 5;
	int          take_max_gap = 5;
	bit          hold_req = 1'b0;

	fractional_clock_enable_pattern dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.ratio_valid (ratio_valid),
		.ratio_stall (ratio_stall),
		.ratio       (ratio),
		.prog_valid  (prog_valid),
		.prog_stall  (prog_stall),
		.prog        (prog)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Run limit.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Record every accepted ratio and check every accepted result.
	always @(posedge clk) begin
		if (arst_n && ratio_valid && !ratio_stall)
			board.note_ratio(ratio);
		if (arst_n && prog_valid && !prog_stall)
			board.check_prog(prog);
	end

	// Result side: random stall before each item, with one long hold-off on request.
	initial begin
		int k;
		@(posedge arst_n);
		forever begin
			if (hold_req) begin
				prog_stall <= 1'b1;
				repeat (LONG_HOLD) @(posedge clk);
				hold_req = 1'b0;
			end else begin
				k = $urandom_range(0, take_max_gap);
				if (k > 0) begin
					prog_stall <= 1'b1;
					repeat (k) @(posedge clk);
				end
			end
			prog_stall <= 1'b0;
			do @(posedge clk); while (!prog_valid);
		end
	end

	// Offers one ratio after a random gap and holds it until it is taken.
	task automatic send_ratio(input logic [RATIO_W-1:0] m, input logic [RATIO_W-1:0] d);
		int gap;
		gap = $urandom_range(0, send_max_gap);
		if (gap > 0) begin
			ratio_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ratio_valid <= 1'b1;
		ratio       <= '{ratio_mult: m, ratio_div: d};
		do @(posedge clk); while (ratio_stall);
	endtask

	// Stops offering, lets the last accepted item be recorded, then waits for all results.
	task automatic wait_drained();
		ratio_valid <= 1'b0;
		@(posedge clk);
		while (board.outstanding() != 0) @(posedge clk);
	endtask

	// Random ratio: mostly in range, biased toward wide mode, some outside the nominal range.
	task automatic send_random_ratio();
		int unsigned m;
		int unsigned d;
		case ($urandom_range(0, 9))
			7: begin
				d = $urandom_range(2, 64);
				m = $urandom_range(1, d / 2);
			end
			8: begin
				m = $urandom_range(0, 127);
				d = $urandom_range(0, 127);
			end
			9: begin
				m = $urandom_range(1, 16);
				d = $urandom_range(1, 16);
			end
			default: begin
				m = $urandom_range(1, 64);
				d = $urandom_range(1, 64);
			end
		endcase
		send_ratio(RATIO_W'(m), RATIO_W'(d));
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < N_DIRECTED; i++)
			send_ratio(DIR_MULT[i], DIR_DIV[i]);

		// Pause until every result is back, then run random phases with varied idling.
		wait_drained();
		for (int phase = 0; phase < 4; phase++) begin
			send_max_gap = (phase == 0 || phase == 2) ? 5 : 0;
			take_max_gap = (phase == 0 || phase == 3) ? 5 : 0;
			// Hold results back so that the block fills and stalls its input.
			if (phase == 2)
				hold_req = 1'b1;
			for (int i = 0; i < N_RANDOM / 4; i++)
				send_random_ratio();
			if (phase == 1)
				wait_drained();
		end
		wait_drained();
		repeat (SETTLE) @(posedge clk);

		if (board.mismatches == 0 && board.outstanding() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end
endmodule
